// File: design/spp_pkg.sv
// spp_pkg: shared widths, codes and types for the segment plane partition block
// no dependencies; used by spp_front, spp_queue, spp_back and segment_plane_partition
`timescale 1ns / 1ps

package spp_pkg;

   // field widths
   localparam int COORD_BITS   = 16;
   localparam int MAX_SEGMENTS = 1024;
   localparam int TAG_BITS     = 8;
   localparam int COEFF_BITS   = 2;
   localparam int OFFSET_BITS  = 17;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = OFFSET_BITS;

   localparam int COST_SPLIT_WEIGHT = 8;

   // derived arithmetic widths
   localparam int CW   = COORD_BITS;
   localparam int VW   = CW + 3;                 // line value at an endpoint
   localparam int DW   = CW + 1;                 // endpoint difference
   localparam int DDW  = DW + 3;                 // cramer divisor
   localparam int PW   = DW + CW;                // difference times coordinate
   localparam int CPW  = OFFSET_BITS + DW;       // offset times difference
   localparam int C2W  = PW + 2;                 // segment line constant
   localparam int NW   = C2W + 3;                // cramer numerator
   localparam int DQW  = CW + 1;                 // quotient magnitude bits
   localparam int DCW  = $clog2(DQW);            // divider step counter
   localparam int CNTW = $clog2(MAX_SEGMENTS + 1);
   localparam int SQW  = 2 * CNTW;
   localparam int COSTW = 21;

   // stream widths
   localparam int REQ_DW  = 4 * CW + TAG_BITS;
   localparam int RSP_RAW = 4 * CW + TAG_BITS + 2 * CNTW + COSTW;
   localparam int RSP_DW  = ((RSP_RAW + 7) / 8) * 8;
   localparam int RSP_PAD = RSP_DW - RSP_RAW;
   localparam int RSP_UW  = 2;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_X_COEFF = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_Y_COEFF = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OFFSET  = 2'd2;

   typedef logic [1:0] kind_type;
   localparam kind_type KIND_LEFT  = 2'd0;
   localparam kind_type KIND_RIGHT = 2'd1;
   localparam kind_type KIND_SPLIT = 2'd2;

   typedef struct packed {
      logic signed [COEFF_BITS-1:0]  x_coeff;
      logic signed [COEFF_BITS-1:0]  y_coeff;
      logic signed [OFFSET_BITS-1:0] offset;
   } cfg_type;

   typedef struct packed {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic [TAG_BITS-1:0]  tag;
      logic                 last;
      kind_type             kind;
      logic                 start_neg;
   } entry_type;

endpackage

// File: design/spp_front.sv
// spp_front: line registers, request intake and side classification
// depends on spp_pkg; feeds spp_queue
`timescale 1ns / 1ps

module spp_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [spp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [spp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [spp_pkg::REQ_DW-1:0]         req_tdata,   // start_x, start_y, end_x, end_y, surface_tag
   input  logic                               req_tlast,   // batch_last
   input  logic                               q_full,
   output logic                               q_push,
   output spp_pkg::entry_type                 q_entry,
   output spp_pkg::cfg_type                   cfg
);

   localparam int CW  = spp_pkg::CW;
   localparam int VW  = spp_pkg::VW;
   localparam int DW  = spp_pkg::DW;
   localparam int DDW = spp_pkg::DDW;

   spp_pkg::cfg_type cfg_ff, cfg_in;

   logic signed [CW-1:0]  ax, ay, bx, by;
   logic signed [VW-1:0]  va, vb;
   logic signed [DW-1:0]  a2, b2;
   logic signed [DDW-1:0] d;
   logic na, nb, za, zb, pa, pb;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            spp_pkg::CSR_X_COEFF: cfg_in.x_coeff = csr_wdata[spp_pkg::COEFF_BITS-1:0];
            spp_pkg::CSR_Y_COEFF: cfg_in.y_coeff = csr_wdata[spp_pkg::COEFF_BITS-1:0];
            spp_pkg::CSR_OFFSET:  cfg_in.offset  = csr_wdata[spp_pkg::OFFSET_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

   assign ax = $signed(req_tdata[CW-1:0]);
   assign ay = $signed(req_tdata[2*CW-1:CW]);
   assign bx = $signed(req_tdata[3*CW-1:2*CW]);
   assign by = $signed(req_tdata[4*CW-1:3*CW]);

   // line value at each endpoint
   assign va = VW'(cfg_ff.x_coeff) * VW'(ax) + VW'(cfg_ff.y_coeff) * VW'(ay)
             + VW'(cfg_ff.offset);
   assign vb = VW'(cfg_ff.x_coeff) * VW'(bx) + VW'(cfg_ff.y_coeff) * VW'(by)
             + VW'(cfg_ff.offset);

   // cramer divisor, zero means parallel lines
   assign a2 = DW'(ay) - DW'(by);
   assign b2 = DW'(bx) - DW'(ax);
   assign d  = DDW'(cfg_ff.x_coeff) * DDW'(b2) - DDW'(cfg_ff.y_coeff) * DDW'(a2);

   assign na = va[VW-1];
   assign nb = vb[VW-1];
   assign za = (va == '0);
   assign zb = (vb == '0);
   assign pa = !na && !za;
   assign pb = !nb && !zb;

   always_comb begin
      q_entry.sx        = ax;
      q_entry.sy        = ay;
      q_entry.ex        = bx;
      q_entry.ey        = by;
      q_entry.tag       = req_tdata[4*CW+spp_pkg::TAG_BITS-1:4*CW];
      q_entry.last      = req_tlast;
      q_entry.start_neg = na;
      if ((na && nb) || (na && zb) || (za && nb)) begin
         q_entry.kind = spp_pkg::KIND_LEFT;
      end else if (((na && pb) || (pa && nb)) && (d != '0)) begin
         q_entry.kind = spp_pkg::KIND_SPLIT;
      end else begin
         q_entry.kind = spp_pkg::KIND_RIGHT;
      end
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

// File: design/spp_queue.sv
// spp_queue: short flop queue of classified segments between front and back
// depends on spp_pkg
`timescale 1ns / 1ps

module spp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  spp_pkg::entry_type push_entry,
   output logic               full,
   output logic               valid,
   output spp_pkg::entry_type head,
   input  logic               pop
);

   spp_pkg::entry_type slot_ff [spp_pkg::QDEPTH];

   logic [spp_pkg::QPW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [spp_pkg::QCW-1:0] count_ff, count_in;
   logic do_pop;

   assign full   = (count_ff == spp_pkg::QCW'(spp_pkg::QDEPTH));
   assign valid  = (count_ff != '0);
   assign head   = slot_ff[rptr_ff];
   assign do_pop = pop && valid;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == spp_pkg::QPW'(spp_pkg::QDEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == spp_pkg::QPW'(spp_pkg::QDEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/spp_back.sv
// spp_back: batch counters, intersection datapath with serial divider, result register
// depends on spp_pkg; takes segments from spp_queue
`timescale 1ns / 1ps

module spp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  spp_pkg::cfg_type            cfg,
   input  logic                        q_valid,
   input  spp_pkg::entry_type          q_entry,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [spp_pkg::RSP_DW-1:0]  rsp_tdata,  // piece_start_x, piece_start_y, piece_end_x,
                                                   // piece_end_y, piece_surface, left_total,
                                                   // right_total, split_cost, zero pad
   output logic                        rsp_tlast,  // run_last
   output logic [spp_pkg::RSP_UW-1:0]  rsp_tuser   // goes_right, batch_done
);

   localparam int CW    = spp_pkg::CW;
   localparam int DW    = spp_pkg::DW;
   localparam int DDW   = spp_pkg::DDW;
   localparam int PW    = spp_pkg::PW;
   localparam int CPW   = spp_pkg::CPW;
   localparam int C2W   = spp_pkg::C2W;
   localparam int NW    = spp_pkg::NW;
   localparam int DQW   = spp_pkg::DQW;
   localparam int DCW   = spp_pkg::DCW;
   localparam int CNTW  = spp_pkg::CNTW;
   localparam int SQW   = spp_pkg::SQW;
   localparam int COSTW = spp_pkg::COSTW;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_C2    = 3'd2;
   localparam logic [2:0] ST_NUM   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_EMIT1 = 3'd5;
   localparam logic [2:0] ST_EMIT2 = 3'd6;

   localparam logic [CNTW-1:0] CNT_MAX = CNTW'(spp_pkg::MAX_SEGMENTS);

   logic [2:0] state_ff, state_in;
   spp_pkg::entry_type work_ff;

   logic [CNTW-1:0] left_ff, left_in, right_ff, right_in, split_ff, split_in;

   // intersection datapath
   logic signed [DW-1:0]  a2, b2;
   logic signed [PW-1:0]  pax_ff, pay_ff;
   logic signed [CPW-1:0] pcb_ff, pca_ff;
   logic signed [DDW-1:0] d_ff;
   logic signed [C2W-1:0] c2_ff;
   logic signed [NW-1:0]  numx, numy;
   logic [DDW-1:0]        dmag;
   logic [NW-1:0]         remx_ff, remy_ff, ds_ff;
   logic [DQW-1:0]        qx_ff, qy_ff, qxs, qys;
   logic                  negx_ff, negy_ff;
   logic [DCW-1:0]        step_ff;
   logic                  gex, gey;
   logic signed [CW-1:0]  cut_x, cut_y;

   // batch totals
   logic [CNTW:0]   lsum, rsum;
   logic [CNTW-1:0] lt, rt, diff;
   logic [SQW:0]    cost_wide;
   logic [CNTW-1:0] lt_ff, rt_ff;
   logic [COSTW-1:0] cost_ff;
   logic            bd_ff;

   // piece selection
   logic out_free, load;
   logic signed [CW-1:0] p_sx, p_sy, p_ex, p_ey;
   logic p_right, p_last, p_bd;
   logic [CNTW-1:0]  p_lt, p_rt;
   logic [COSTW-1:0] p_cost;

   logic                        rsp_tvalid_ff;
   logic [spp_pkg::RSP_DW-1:0]  rsp_tdata_ff;
   logic                        rsp_tlast_ff;
   logic [spp_pkg::RSP_UW-1:0]  rsp_tuser_ff;

   function automatic logic [CNTW-1:0] sat_inc(input logic [CNTW-1:0] v);
      sat_inc = (v < CNT_MAX) ? v + 1'b1 : CNT_MAX;
   endfunction

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign load     = ((state_ff == ST_EMIT1) || (state_ff == ST_EMIT2)) && out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               state_in = (q_entry.kind == spp_pkg::KIND_SPLIT) ? ST_MUL : ST_EMIT1;
            end
         end
         ST_MUL: state_in = ST_C2;
         ST_C2:  state_in = ST_NUM;
         ST_NUM: state_in = ST_DIV;
         ST_DIV: begin
            if (step_ff == '0) begin
               state_in = ST_EMIT1;
            end
         end
         ST_EMIT1: begin
            if (out_free) begin
               state_in = (work_ff.kind == spp_pkg::KIND_SPLIT) ? ST_EMIT2 : ST_IDLE;
            end
         end
         ST_EMIT2: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // batch counters: bumped at pop, cleared when the batch end leaves
   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      split_in = split_ff;
      if (q_pop) begin
         case (q_entry.kind)
            spp_pkg::KIND_LEFT:  left_in  = sat_inc(left_ff);
            spp_pkg::KIND_SPLIT: split_in = sat_inc(split_ff);
            default:             right_in = sat_inc(right_ff);
         endcase
      end else if (state_ff == ST_EMIT1 && out_free && work_ff.last) begin
         left_in  = '0;
         right_in = '0;
         split_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_ff  <= '0;
         right_ff <= '0;
         split_ff <= '0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
         right_ff <= right_in;
         split_ff <= split_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         work_ff <= q_entry;
      end
   end

   // segment's own line and cramer products
   assign a2 = DW'(work_ff.sy) - DW'(work_ff.ey);
   assign b2 = DW'(work_ff.ex) - DW'(work_ff.sx);

   assign numx = -NW'(pcb_ff) + NW'(cfg.y_coeff) * NW'(c2_ff);
   assign numy = -(NW'(cfg.x_coeff) * NW'(c2_ff)) + NW'(pca_ff);
   assign dmag = d_ff[DDW-1] ? DDW'(-d_ff) : DDW'(d_ff);

   assign gex = (remx_ff >= ds_ff);
   assign gey = (remy_ff >= ds_ff);

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_MUL: begin
            pax_ff <= PW'(a2) * PW'(work_ff.sx);
            pay_ff <= PW'(b2) * PW'(work_ff.sy);
            pcb_ff <= CPW'(cfg.offset) * CPW'(b2);
            pca_ff <= CPW'(cfg.offset) * CPW'(a2);
            d_ff   <= DDW'(cfg.x_coeff) * DDW'(b2) - DDW'(cfg.y_coeff) * DDW'(a2);
         end
         ST_C2: begin
            c2_ff <= -(C2W'(pax_ff) + C2W'(pay_ff));
         end
         ST_NUM: begin
            remx_ff <= numx[NW-1] ? NW'(-numx) : NW'(numx);
            remy_ff <= numy[NW-1] ? NW'(-numy) : NW'(numy);
            negx_ff <= numx[NW-1] ^ d_ff[DDW-1];
            negy_ff <= numy[NW-1] ^ d_ff[DDW-1];
            ds_ff   <= NW'(dmag) << (DQW - 1);
            qx_ff   <= '0;
            qy_ff   <= '0;
            step_ff <= DCW'(DQW - 1);
         end
         ST_DIV: begin
            // one restoring step per cycle, both coordinates share the divisor
            remx_ff <= gex ? remx_ff - ds_ff : remx_ff;
            remy_ff <= gey ? remy_ff - ds_ff : remy_ff;
            qx_ff   <= {qx_ff[DQW-2:0], gex};
            qy_ff   <= {qy_ff[DQW-2:0], gey};
            ds_ff   <= ds_ff >> 1;
            step_ff <= step_ff - 1'b1;
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   // truncation toward zero: divide magnitudes, then apply the sign
   assign qxs   = negx_ff ? -qx_ff : qx_ff;
   assign qys   = negy_ff ? -qy_ff : qy_ff;
   assign cut_x = $signed(qxs[CW-1:0]);
   assign cut_y = $signed(qys[CW-1:0]);

   // totals from the counters as they stand at the batch end
   assign lsum = {1'b0, left_ff} + {1'b0, split_ff};
   assign rsum = {1'b0, right_ff} + {1'b0, split_ff};
   assign lt   = (lsum > (CNTW+1)'(spp_pkg::MAX_SEGMENTS)) ? CNT_MAX : lsum[CNTW-1:0];
   assign rt   = (rsum > (CNTW+1)'(spp_pkg::MAX_SEGMENTS)) ? CNT_MAX : rsum[CNTW-1:0];
   assign diff = (left_ff >= right_ff) ? left_ff - right_ff : right_ff - left_ff;
   assign cost_wide = (SQW+1)'(diff) * (SQW+1)'(diff)
                    + (SQW+1)'(split_ff) * (SQW+1)'(spp_pkg::COST_SPLIT_WEIGHT);

   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT1 && out_free) begin
         bd_ff   <= work_ff.last;
         lt_ff   <= lt;
         rt_ff   <= rt;
         cost_ff <= cost_wide[COSTW-1:0];
      end
   end

   always_comb begin
      p_sx    = work_ff.sx;
      p_sy    = work_ff.sy;
      p_ex    = work_ff.ex;
      p_ey    = work_ff.ey;
      p_right = (work_ff.kind == spp_pkg::KIND_RIGHT);
      p_last  = 1'b1;
      p_bd    = work_ff.last;
      p_lt    = work_ff.last ? lt : '0;
      p_rt    = work_ff.last ? rt : '0;
      p_cost  = work_ff.last ? cost_wide[COSTW-1:0] : '0;
      if (state_ff == ST_EMIT2) begin
         p_right = 1'b1;
         p_bd    = bd_ff;
         p_lt    = bd_ff ? lt_ff : '0;
         p_rt    = bd_ff ? rt_ff : '0;
         p_cost  = bd_ff ? cost_ff : '0;
         if (work_ff.start_neg) begin
            p_sx = cut_x;
            p_sy = cut_y;
         end else begin
            p_ex = cut_x;
            p_ey = cut_y;
         end
      end else if (work_ff.kind == spp_pkg::KIND_SPLIT) begin
         // left piece first
         p_right = 1'b0;
         p_last  = 1'b0;
         if (work_ff.start_neg) begin
            p_ex = cut_x;
            p_ey = cut_y;
         end else begin
            p_sx = cut_x;
            p_sy = cut_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_tdata_ff <= {{spp_pkg::RSP_PAD{1'b0}}, p_cost, p_rt, p_lt, work_ff.tag,
                          p_ey, p_ex, p_sy, p_sx};
         rsp_tlast_ff <= p_last;
         rsp_tuser_ff <= {p_bd, p_right};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   // a piece that does not close its request is always the left half of a cut
   a_first_piece_left: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff && !rsp_tlast_ff |-> !rsp_tuser_ff[0])
      else $error("non-final piece is not a left piece");

   // a second piece only follows a cut segment
   a_emit2_split: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT2 |-> work_ff.kind == spp_pkg::KIND_SPLIT)
      else $error("second piece for an unsplit segment");

   // the divider never runs with a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> ds_ff != '0)
      else $error("divider started with zero divisor");

   // counters stay within the batch limit
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      left_ff <= CNT_MAX && right_ff <= CNT_MAX && split_ff <= CNT_MAX)
      else $error("batch counter above limit");

   // counters are empty right after a batch end piece goes out
   a_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT1 && out_free && work_ff.last |=>
         left_ff == '0 && right_ff == '0 && split_ff == '0)
      else $error("counters not cleared at batch end");
`endif

endmodule

// File: design/segment_plane_partition.sv
// segment_plane_partition: top level, sorts 2D segments against a configured line
// depends on spp_pkg, spp_front, spp_queue, spp_back
//
//   port group  direction  role
//   req_*       in         segment request: endpoints, surface tag, batch end on tlast
//   rsp_*       out        emitted piece: side and batch-done in tuser, run end on tlast
//   csr_*       in         line coefficients and offset, write only
//
// an unsplit segment in the back end goes through queue pop, then result register load
// a cut segment goes through queue pop, 3 product and numerator steps, 17 steps of the shared
// restoring divider, and two result loads; the divider sets the rate for cuts
// the front takes a request whenever the 2-entry queue has room, independent of rsp_tready
// reset is synchronous and clears the line registers, queue, counters and result valid
`timescale 1ns / 1ps

module segment_plane_partition (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [spp_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [spp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [spp_pkg::REQ_DW-1:0]         req_tdata,   // start_x, start_y, end_x, end_y, surface_tag
   input  logic                               req_tlast,   // batch_last
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [spp_pkg::RSP_DW-1:0]         rsp_tdata,   // piece_start_x, piece_start_y,
                                                           // piece_end_x, piece_end_y,
                                                           // piece_surface, left_total,
                                                           // right_total, split_cost, zero pad
   output logic                               rsp_tlast,   // run_last
   output logic [spp_pkg::RSP_UW-1:0]         rsp_tuser    // goes_right, batch_done
);

   spp_pkg::cfg_type   cfg;
   spp_pkg::entry_type push_entry, head;
   logic q_push, q_full, q_valid, q_pop;

   spp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (push_entry),
      .cfg        (cfg)
   );

   spp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .valid      (q_valid),
      .head       (head),
      .pop        (q_pop)
   );

   spp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_entry    (head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// File: bench/testbench.sv
// testbench: drives segment requests into segment_plane_partition and checks every piece
// against an in-bench predictor of the side sort, the cut point and the batch totals
// depends on spp_pkg and the segment_plane_partition rtl
`timescale 1ns / 1ps

module testbench;

   localparam int CW                = spp_pkg::CW;
   localparam int TAG_BITS          = spp_pkg::TAG_BITS;
   localparam int CNTW              = spp_pkg::CNTW;
   localparam int COSTW             = spp_pkg::COSTW;
   localparam int COEFF_BITS        = spp_pkg::COEFF_BITS;
   localparam int OFFSET_BITS       = spp_pkg::OFFSET_BITS;
   localparam int CSR_IDX_BITS      = spp_pkg::CSR_IDX_BITS;
   localparam int CSR_DATA_BITS     = spp_pkg::CSR_DATA_BITS;
   localparam int MAX_SEGMENTS      = spp_pkg::MAX_SEGMENTS;
   localparam int COST_SPLIT_WEIGHT = spp_pkg::COST_SPLIT_WEIGHT;
   localparam int REQ_DW            = spp_pkg::REQ_DW;
   localparam int RSP_DW            = spp_pkg::RSP_DW;
   localparam int RSP_UW            = spp_pkg::RSP_UW;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LT_LSB      = 4 * CW + TAG_BITS;
   localparam int RT_LSB      = LT_LSB + CNTW;
   localparam int COST_LSB    = RT_LSB + CNTW;
   localparam int SETTLE      = 30;

   typedef struct {
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic [TAG_BITS-1:0]  tag;
      logic                 last;
   } segment_type;

   typedef struct {
      logic                 goes_right;
      logic signed [CW-1:0] sx;
      logic signed [CW-1:0] sy;
      logic signed [CW-1:0] ex;
      logic signed [CW-1:0] ey;
      logic [TAG_BITS-1:0]  surface;
      logic                 run_last;
      logic                 batch_done;
      logic [CNTW-1:0]      left_total;
      logic [CNTW-1:0]      right_total;
      logic [COSTW-1:0]     cost;
   } piece_type;

   class partition_scoreboard;
      piece_type expected_pieces[$];
      int errors;
      logic signed [COEFF_BITS-1:0]  x_coeff;
      logic signed [COEFF_BITS-1:0]  y_coeff;
      logic signed [OFFSET_BITS-1:0] offset;
      int left_count;
      int right_count;
      int split_count;

      function new();
         errors = 0;
         x_coeff = '0;
         y_coeff = '0;
         offset = '0;
         left_count = 0;
         right_count = 0;
         split_count = 0;
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
         case (index)
            spp_pkg::CSR_X_COEFF: x_coeff = value[COEFF_BITS-1:0];
            spp_pkg::CSR_Y_COEFF: y_coeff = value[COEFF_BITS-1:0];
            spp_pkg::CSR_OFFSET: offset = value[OFFSET_BITS-1:0];
            default: ;
         endcase
      endfunction

      static function int bump(int count);
         return (count < MAX_SEGMENTS) ? count + 1 : MAX_SEGMENTS;
      endfunction

      static function piece_type make_piece(logic right, longint sx, longint sy, longint ex,
                                            longint ey, logic [TAG_BITS-1:0] tag);
         piece_type p;
         p.goes_right = right;
         p.sx = sx[CW-1:0];
         p.sy = sy[CW-1:0];
         p.ex = ex[CW-1:0];
         p.ey = ey[CW-1:0];
         p.surface = tag;
         p.run_last = 1'b0;
         p.batch_done = 1'b0;
         p.left_total = '0;
         p.right_total = '0;
         p.cost = '0;
         return p;
      endfunction

      // sort one accepted segment and queue the pieces it must produce
      function void note_segment(segment_type seg);
         longint a, b, c, ax, ay, bx, by, va, vb, a2, b2, c2, d, cut_x, cut_y;
         logic [63:0] cost_full;
         int sa, sb, lt, rt, diff;
         piece_type run[$];
         a = x_coeff;
         b = y_coeff;
         c = offset;
         ax = seg.sx;
         ay = seg.sy;
         bx = seg.ex;
         by = seg.ey;
         va = a * ax + b * ay + c;
         vb = a * bx + b * by + c;
         sa = int'(va > 0) - int'(va < 0);
         sb = int'(vb > 0) - int'(vb < 0);
         a2 = ay - by;
         b2 = bx - ax;
         c2 = -(a2 * ax + b2 * ay);
         d = a * b2 - b * a2;
         if (sa + sb < 0) begin
            run.push_back(make_piece(1'b0, ax, ay, bx, by, seg.tag));
            left_count = bump(left_count);
         end else if (sa + sb > 0 || (sa == 0 && sb == 0) || d == 0) begin
            run.push_back(make_piece(1'b1, ax, ay, bx, by, seg.tag));
            right_count = bump(right_count);
         end else begin
            // cramer cut, quotient truncated toward zero
            cut_x = (-c * b2 + b * c2) / d;
            cut_y = (-a * c2 + c * a2) / d;
            if (va < 0) begin
               run.push_back(make_piece(1'b0, ax, ay, cut_x, cut_y, seg.tag));
               run.push_back(make_piece(1'b1, cut_x, cut_y, bx, by, seg.tag));
            end else begin
               run.push_back(make_piece(1'b0, cut_x, cut_y, bx, by, seg.tag));
               run.push_back(make_piece(1'b1, ax, ay, cut_x, cut_y, seg.tag));
            end
            split_count = bump(split_count);
         end
         run[run.size() - 1].run_last = 1'b1;
         if (seg.last) begin
            lt = left_count + split_count;
            rt = right_count + split_count;
            if (lt > MAX_SEGMENTS) lt = MAX_SEGMENTS;
            if (rt > MAX_SEGMENTS) rt = MAX_SEGMENTS;
            diff = left_count - right_count;
            cost_full = longint'(diff) * diff + COST_SPLIT_WEIGHT * split_count;
            foreach (run[i]) begin
               run[i].batch_done = 1'b1;
               run[i].left_total = lt[CNTW-1:0];
               run[i].right_total = rt[CNTW-1:0];
               run[i].cost = cost_full[COSTW-1:0];
            end
            left_count = 0;
            right_count = 0;
            split_count = 0;
         end
         foreach (run[i]) expected_pieces.push_back(run[i]);
      endfunction

      function void compare(string field, longint want, longint got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_piece(piece_type got);
         piece_type want;
         if (expected_pieces.size() == 0) begin
            $error("piece with no request outstanding, surface %0d", got.surface);
            errors++;
            return;
         end
         want = expected_pieces.pop_front();
         compare("goes_right", want.goes_right, got.goes_right);
         compare("piece_start_x", want.sx, got.sx);
         compare("piece_start_y", want.sy, got.sy);
         compare("piece_end_x", want.ex, got.ex);
         compare("piece_end_y", want.ey, got.ey);
         compare("piece_surface", want.surface, got.surface);
         compare("run_last", want.run_last, got.run_last);
         compare("batch_done", want.batch_done, got.batch_done);
         compare("left_total", want.left_total, got.left_total);
         compare("right_total", want.right_total, got.right_total);
         compare("split_cost", want.cost, got.cost);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DW-1:0]        req_tdata;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DW-1:0]        rsp_tdata;
   logic                     rsp_tlast;
   logic [RSP_UW-1:0]        rsp_tuser;

   bit steady = 1'b0;
   int cycle_count = 0;
   partition_scoreboard board;

   segment_plane_partition DUT (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin : rsp_monitor
      piece_type got;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset && rsp_tvalid && rsp_tready) begin
         got.goes_right = rsp_tuser[0];
         got.batch_done = rsp_tuser[1];
         got.run_last = rsp_tlast;
         got.sx = rsp_tdata[0 +: CW];
         got.sy = rsp_tdata[CW +: CW];
         got.ex = rsp_tdata[2 * CW +: CW];
         got.ey = rsp_tdata[3 * CW +: CW];
         got.surface = rsp_tdata[4 * CW +: TAG_BITS];
         got.left_total = rsp_tdata[LT_LSB +: CNTW];
         got.right_total = rsp_tdata[RT_LSB +: CNTW];
         got.cost = rsp_tdata[COST_LSB +: COSTW];
         board.check_piece(got);
      end
   end

   task automatic write_register(logic [CSR_IDX_BITS-1:0] index, int value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_BITS-1:0];
      board.set_register(index, value[CSR_DATA_BITS-1:0]);
      @(posedge clock);
   endtask

   task automatic set_plane(int x_coeff, int y_coeff, int offset);
      write_register(spp_pkg::CSR_X_COEFF, x_coeff);
      write_register(spp_pkg::CSR_Y_COEFF, y_coeff);
      write_register(spp_pkg::CSR_OFFSET, offset);
      csr_we <= 1'b0;
   endtask

   // called right after a rising edge; returns right after the accepting edge
   task automatic send_segment(segment_type seg);
      if (!steady && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(99) < 29);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {seg.tag, seg.ey, seg.ex, seg.sy, seg.sx};
      req_tlast <= seg.last;
      do @(posedge clock); while (!req_tready);
      board.note_segment(seg);
   endtask

   task automatic wait_for_pieces();
      req_tvalid <= 1'b0;
      while (board.expected_pieces.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic send(int sx, int sy, int ex, int ey, int tag, bit last);
      segment_type seg;
      seg.sx = sx[CW-1:0];
      seg.sy = sy[CW-1:0];
      seg.ex = ex[CW-1:0];
      seg.ey = ey[CW-1:0];
      seg.tag = tag[TAG_BITS-1:0];
      seg.last = last;
      send_segment(seg);
   endtask

   function automatic logic signed [CW-1:0] clamp_coord(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[CW-1:0];
   endfunction

   // mix of full-range segments, short and long segments straddling the line,
   // and segments built from the coordinate extremes
   function automatic segment_type random_segment();
      segment_type seg;
      int corners[6] = '{-32768, -32767, -1, 0, 1, 32767};
      longint a, b, c, cx, cy, spread;
      int pick;
      pick = $urandom_range(99);
      seg.tag = TAG_BITS'($urandom);
      seg.last = ($urandom_range(7) == 0);
      if (pick < 45) begin
         seg.sx = CW'($urandom);
         seg.sy = CW'($urandom);
         seg.ex = CW'($urandom);
         seg.ey = CW'($urandom);
      end else if (pick < 85) begin
         a = board.x_coeff;
         b = board.y_coeff;
         c = board.offset;
         cx = longint'($urandom_range(60000)) - 30000;
         cy = longint'($urandom_range(60000)) - 30000;
         if (a != 0) cx = -(c + b * cy) / a;
         else if (b != 0) cy = -c / b;
         spread = (pick < 65) ? 4 : 4000;
         seg.sx = clamp_coord(cx + longint'($urandom_range(2 * spread)) - spread);
         seg.sy = clamp_coord(cy + longint'($urandom_range(2 * spread)) - spread);
         seg.ex = clamp_coord(cx + longint'($urandom_range(2 * spread)) - spread);
         seg.ey = clamp_coord(cy + longint'($urandom_range(2 * spread)) - spread);
      end else begin
         seg.sx = CW'(corners[$urandom_range(5)]);
         seg.sy = CW'(corners[$urandom_range(5)]);
         seg.ex = CW'(corners[$urandom_range(5)]);
         seg.ey = CW'(corners[$urandom_range(5)]);
      end
      return seg;
   endfunction

   task automatic random_phase(int count);
      int offset;
      case ($urandom_range(2))
         0: offset = $urandom_range(40) - 20;
         1: offset = $urandom_range(131071);
         default: offset = $urandom_range(1) ? 65535 : -65536;
      endcase
      set_plane($urandom_range(3), $urandom_range(3), offset);
      repeat (count) send_segment(random_segment());
      wait_for_pieces();
   endtask

   initial begin
      segment_type seg;
      int phase_x[5] = '{-1, 1, -2, 0, 0};
      int phase_y[5] = '{-1, 1, -2, 0, -1};
      int phase_c[5] = '{0, 65535, -65536, 5, -1};
      board = new();
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // line all zero after reset: every point sits on it, so all go right
      send(-32768, -32768, 32767, 32767, 0, 0);
      send(32767, -32768, -32768, 32767, 255, 1);
      wait_for_pieces();

      set_plane(1, -1, 0);
      send(-5, 0, -3, 1, 1, 0);               // both below
      send(5, 0, 3, 1, 2, 0);                 // both above
      send(7, 7, -2, -2, 3, 0);               // both on the line
      send(0, 0, 4, 1, 4, 0);                 // on the line and above
      send(0, 0, -4, 1, 5, 0);                // on the line and below
      send(-10, 0, 10, 0, 6, 0);              // cut, start below
      send(10, 3, -7, 4, 7, 0);               // cut, start above, truncated quotient
      send(0, 5, 9, 14, 8, 0);                // parallel to the line
      send(-32768, 32767, 32767, -32768, 9, 1);
      wait_for_pieces();

      set_plane(-2, 1, 65535);
      send(32767, -32768, 0, 0, 10, 0);
      send(32767, -5, 100, 7, 11, 0);
      send(100, 7, 32767, -5, 12, 1);
      wait_for_pieces();

      set_plane(1, -2, -65536);
      send(32767, -32768, 32767, 32767, 13, 0);
      send(-32768, -32768, 32767, -32768, 14, 0);
      send(32767, -32768, -32768, 32767, 165, 1);
      wait_for_pieces();

      set_plane(0, 1, 0);
      send(3, -3, 3, 3, 170, 1);              // single-segment batch
      wait_for_pieces();

      for (int p = 0; p < 5; p++) begin
         if (p == 2) steady <= 1'b1;
         set_plane(phase_x[p], phase_y[p], phase_c[p]);
         repeat (45) send_segment(random_segment());
         wait_for_pieces();
         steady <= 1'b0;
      end

      // one long batch, nearly all left, drives counts and totals into saturation
      set_plane(1, 0, 0);
      for (int i = 0; i < 1060; i++) begin
         if ($urandom_range(99) < 2) begin
            seg = random_segment();
         end else begin
            seg.sx = CW'(-$urandom_range(32768));
            seg.ex = CW'(-$urandom_range(32768));
            seg.sy = CW'($urandom);
            seg.ey = CW'($urandom);
            seg.tag = TAG_BITS'($urandom);
         end
         seg.last = (i == 1059);
         send_segment(seg);
      end
      wait_for_pieces();

      repeat (2) random_phase(25);

      if (board.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: segment_plane_partition.f
design/spp_pkg.sv
design/spp_front.sv
design/spp_queue.sv
design/spp_back.sv
design/segment_plane_partition.sv
bench/testbench.sv
